/* rtl/sv39ptw_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the Sv39 page table walker.
// No dependencies; used by the table RAM and the top level.
package sv39ptw_pkg;

    localparam int PPN_W  = 44;
    localparam int VA_W   = 39;
    localparam int PA_W   = 56;
    localparam int PTE_W  = 64;
    localparam int WIDX_W = 12;
    localparam int VPN_W  = 9;
    localparam int OFF_W  = 12;

    localparam int PTE_V       = 0;
    localparam int PTE_U       = 4;
    localparam int PTE_PPN_LSB = 10;

    localparam int DEF_TABLE_WORDS = 4096;

    localparam logic CMD_WRITE     = 1'b0;
    localparam logic CMD_TRANSLATE = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK
    } t_state;

endpackage

/* rtl/sv39ptw_table_ram.sv */
`timescale 1ns / 1ps
// Page table entry RAM: one write port, one read port with registered data.
// Depends on sv39ptw_pkg for the entry width.
module sv39ptw_table_ram #(
    parameter int TABLE_WORDS = sv39ptw_pkg::DEF_TABLE_WORDS,
    parameter int AW          = $clog2(TABLE_WORDS)
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [AW-1:0]                 i_waddr,
    input  logic [sv39ptw_pkg::PTE_W-1:0] i_wdata,
    input  logic                          i_re,
    input  logic [AW-1:0]                 i_raddr,
    output logic [sv39ptw_pkg::PTE_W-1:0] o_rdata
);

    logic [sv39ptw_pkg::PTE_W-1:0] r_mem [TABLE_WORDS];
    logic [sv39ptw_pkg::PTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/sv39_page_table_walker_top.sv */
`timescale 1ns / 1ps
// Sv39 page table walker top level: sequencer, root register, result register.
// Depends on sv39ptw_pkg and sv39ptw_table_ram.
//
// After reset the block sweeps its table RAM to zero, one word a cycle, with
// busy high; root_page_number may be written meanwhile. TABLE_WORDS must be a
// power of two; the block does not enforce it. A write item is written in the
// cycle it is accepted and its result appears on the next. A translate of an
// address at or above 2^38 faults on the next cycle. Any other translate reads
// one entry per level through the single RAM read port until an invalid
// pointer or the level 0 leaf ends the walk. A full walk steps through ST_WALK
// at levels 2, 1 and 0 with busy high and o_done registered from the last step;
// a walk stopped by an invalid entry at level 2 or 1 ends there. A new item may
// start in the cycle that the result is shown. Results are held for exactly one
// cycle and cannot be stalled, so the receiver must take every o_done pulse.
module sv39_page_table_walker_top #(
    parameter int TABLE_WORDS = sv39ptw_pkg::DEF_TABLE_WORDS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sv39ptw_pkg::PPN_W-1:0]  i_root_page_number,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_command,
    input  logic [sv39ptw_pkg::VA_W-1:0]   i_virt_addr,
    input  logic [sv39ptw_pkg::WIDX_W-1:0] i_word_index,
    input  logic [sv39ptw_pkg::PTE_W-1:0]  i_pte_value,
    output logic                           o_done,
    output logic [sv39ptw_pkg::PA_W-1:0]   o_phys_addr,
    output logic                           o_fault
);

    localparam int AW     = $clog2(TABLE_WORDS);
    localparam int FULL_W = sv39ptw_pkg::PPN_W + sv39ptw_pkg::VPN_W;
    localparam logic [AW-1:0] LAST_WORD = AW'(TABLE_WORDS - 1);

    sv39ptw_pkg::t_state r_state, n_state;

    logic [sv39ptw_pkg::PPN_W-1:0] r_root;
    logic [1:0]                    r_level, n_level;
    logic [29:0]                   r_va;
    logic [AW-1:0]                 r_clr_cnt;
    logic                          r_done, n_done;
    logic [sv39ptw_pkg::PA_W-1:0]  r_phys, n_phys;
    logic                          r_fault, n_fault;

    logic                          accept;
    logic                          is_write;
    logic                          out_of_range;
    logic                          walk_go;
    logic                          descend;
    logic                          leaf_ok;
    logic [sv39ptw_pkg::PTE_W-1:0] pte;
    logic [sv39ptw_pkg::PPN_W-1:0] pte_ppn;
    logic [sv39ptw_pkg::VPN_W-1:0] next_idx;
    logic [FULL_W-1:0]             rd_full;
    logic [FULL_W-1:0]             wr_full;

    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic [sv39ptw_pkg::PTE_W-1:0] ram_wdata;
    logic                          ram_re;
    logic [AW-1:0]                 ram_raddr;
    logic [sv39ptw_pkg::PTE_W-1:0] ram_rdata_w;

    assign busy         = (r_state != sv39ptw_pkg::ST_IDLE);
    assign accept       = start && !busy;
    assign is_write     = (i_command == sv39ptw_pkg::CMD_WRITE);
    assign out_of_range = i_virt_addr[sv39ptw_pkg::VA_W-1];
    assign walk_go      = accept && !is_write && !out_of_range;

    assign pte     = ram_rdata_w;
    assign pte_ppn = pte[sv39ptw_pkg::PTE_PPN_LSB +: sv39ptw_pkg::PPN_W];
    assign descend = pte[sv39ptw_pkg::PTE_V] && (r_level != 2'd0);
    assign leaf_ok = pte[sv39ptw_pkg::PTE_V] && pte[sv39ptw_pkg::PTE_U];

    sv39ptw_table_ram #(
        .TABLE_WORDS (TABLE_WORDS),
        .AW          (AW)
    ) u_table_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata_w)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sv39ptw_pkg::ST_CLEAR: begin
                if (r_clr_cnt == LAST_WORD) begin
                    n_state = sv39ptw_pkg::ST_IDLE;
                end
            end
            sv39ptw_pkg::ST_IDLE: begin
                if (walk_go) begin
                    n_state = sv39ptw_pkg::ST_WALK;
                end
            end
            sv39ptw_pkg::ST_WALK: begin
                if (!descend) begin
                    n_state = sv39ptw_pkg::ST_IDLE;
                end
            end
            default: n_state = sv39ptw_pkg::ST_CLEAR;
        endcase
    end

    // datapath control and results
    always_comb begin
        case (r_level)
            2'd2:    next_idx = r_va[29:21];
            default: next_idx = r_va[20:12];
        endcase

        wr_full   = FULL_W'(i_word_index);
        ram_we    = 1'b0;
        ram_waddr = wr_full[AW-1:0];
        ram_wdata = i_pte_value;
        ram_re    = 1'b0;
        rd_full   = {pte_ppn, next_idx};
        n_level   = r_level;
        n_done    = 1'b0;
        n_phys    = '0;
        n_fault   = 1'b0;

        unique case (r_state)
            sv39ptw_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_cnt;
                ram_wdata = '0;
            end
            sv39ptw_pkg::ST_IDLE: begin
                rd_full = {r_root, i_virt_addr[38:30]};
                if (accept) begin
                    if (is_write) begin
                        ram_we = 1'b1;
                        n_done = 1'b1;
                    end else if (out_of_range) begin
                        n_done  = 1'b1;
                        n_fault = 1'b1;
                    end else begin
                        ram_re  = 1'b1;
                        n_level = 2'd2;
                    end
                end
            end
            sv39ptw_pkg::ST_WALK: begin
                if (descend) begin
                    ram_re  = 1'b1;
                    n_level = r_level - 2'd1;
                end else begin
                    n_done  = 1'b1;
                    n_level = 2'd2;
                    if (r_level == 2'd0 && leaf_ok) begin
                        n_phys = {pte_ppn, r_va[11:0]};
                    end else begin
                        n_fault = 1'b1;
                    end
                end
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase

        ram_raddr = rd_full[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= sv39ptw_pkg::ST_CLEAR;
            r_clr_cnt <= '0;
            r_level   <= 2'd2;
            r_root    <= '0;
            r_done    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_level <= n_level;
            r_done  <= n_done;
            if (r_state == sv39ptw_pkg::ST_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + AW'(1);
            end
            if (i_cfg_we) begin
                r_root <= i_root_page_number;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (walk_go) begin
            r_va <= i_virt_addr[29:0];
        end
        r_phys  <= n_phys;
        r_fault <= n_fault;
    end

    assign o_done      = r_done;
    assign o_phys_addr = r_phys;
    assign o_fault     = r_fault;

    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sv39ptw_pkg::ST_CLEAR) |-> !r_done)
        else $error("result strobe during clearing pass");

    a_walk_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sv39ptw_pkg::ST_WALK) |-> (r_level != 2'd3))
        else $error("walk level out of range");

    a_walk_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        walk_go |=> (r_state == sv39ptw_pkg::ST_WALK && r_level == 2'd2))
        else $error("walk did not start at the root level");

    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(accept || r_state == sv39ptw_pkg::ST_WALK))
        else $error("result without an item");

    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_fault) |-> (o_phys_addr == '0))
        else $error("faulted result carries an address");

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for the Sv39 page table walker: builds table chains,
// translates through them and checks every result against a shadow walk (writes expect zero).
// Depends on sv39ptw_pkg and the RTL top level sv39_page_table_walker_top.
module tb_top;

    localparam int TABLE_WORDS = sv39ptw_pkg::DEF_TABLE_WORDS;
    localparam int PA_W        = sv39ptw_pkg::PA_W;
    localparam int PPN_W       = sv39ptw_pkg::PPN_W;
    localparam int VA_W        = sv39ptw_pkg::VA_W;
    localparam int WIDX_W      = sv39ptw_pkg::WIDX_W;
    localparam int PTE_W       = sv39ptw_pkg::PTE_W;
    localparam int VPN_W       = sv39ptw_pkg::VPN_W;
    localparam int OFF_W       = sv39ptw_pkg::OFF_W;
    localparam int PTE_V       = sv39ptw_pkg::PTE_V;
    localparam int PTE_U       = sv39ptw_pkg::PTE_U;
    localparam int PTE_PPN_LSB = sv39ptw_pkg::PTE_PPN_LSB;

    typedef struct packed {
        logic [PA_W-1:0] pa;
        logic            fault;
    } t_walk_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [PPN_W-1:0]    i_root_page_number;
    logic                start;
    logic                busy;
    logic                i_command;
    logic [VA_W-1:0]     i_virt_addr;
    logic [WIDX_W-1:0]   i_word_index;
    logic [PTE_W-1:0]    i_pte_value;
    logic                o_done;
    logic [PA_W-1:0]     o_phys_addr;
    logic                o_fault;

    logic [PTE_W-1:0]    pte_shadow [TABLE_WORDS];
    logic [PPN_W-1:0]    root_ppn_shadow;
    t_walk_result        pending_walks [$];
    t_walk_result        oldest_walk;
    int                  errors = 0;
    int                  items_sent = 0;
    int                  next_pause = 160;
    bit                  idle_allowed = 1'b1;

    sv39_page_table_walker_top #(
        .TABLE_WORDS(TABLE_WORDS)
    ) i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_root_page_number (i_root_page_number),
        .start              (start),
        .busy               (busy),
        .i_command          (i_command),
        .i_virt_addr        (i_virt_addr),
        .i_word_index       (i_word_index),
        .i_pte_value        (i_pte_value),
        .o_done             (o_done),
        .o_phys_addr        (o_phys_addr),
        .o_fault            (o_fault)
    );

    always #2 i_clk = ~i_clk;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [PPN_W-1:0] rand_ppn();
        logic [63:0] r;
        r = rand64();
        return r[PPN_W-1:0];
    endfunction

    function automatic logic [WIDX_W-1:0] word_of(input logic [PPN_W-1:0] pg,
                                                  input logic [VPN_W-1:0] idx);
        logic [63:0] w;
        w = ({20'd0, pg} << VPN_W) + {55'd0, idx};
        w = w % 64'(TABLE_WORDS);
        return w[WIDX_W-1:0];
    endfunction

    function automatic logic [PTE_W-1:0] make_pointer(input logic [PPN_W-1:0] pg);
        logic [63:0] r;
        r = rand64();
        r[PTE_PPN_LSB +: PPN_W] = pg;
        r[PTE_V] = 1'b1;
        return r;
    endfunction

    function automatic t_walk_result walk_tables(input logic [VA_W-1:0] va);
        t_walk_result     r;
        logic [PPN_W-1:0] pg;
        logic [PTE_W-1:0] entry;
        logic [VPN_W-1:0] idx;
        bit               bad;
        int               lvl;
        r = '0;
        if (va[VA_W-1]) begin
            r.fault = 1'b1;
            return r;
        end
        pg = root_ppn_shadow;
        bad = 1'b0;
        for (lvl = 2; lvl > 0 && !bad; lvl--) begin
            idx = va[OFF_W + VPN_W * lvl +: VPN_W];
            entry = pte_shadow[word_of(pg, idx)];
            if (!entry[PTE_V])
                bad = 1'b1;
            else
                pg = entry[PTE_PPN_LSB +: PPN_W];
        end
        if (!bad) begin
            entry = pte_shadow[word_of(pg, va[OFF_W +: VPN_W])];
            if (!entry[PTE_V] || !entry[PTE_U])
                bad = 1'b1;
            else
                r.pa = {entry[PTE_PPN_LSB +: PPN_W], va[OFF_W-1:0]};
        end
        r.fault = bad;
        return r;
    endfunction

    task automatic send_item(input logic cmd, input logic [VA_W-1:0] va,
                             input logic [WIDX_W-1:0] widx, input logic [PTE_W-1:0] pte);
        t_walk_result r;
        if (idle_allowed && $urandom_range(0, 99) < 9) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_command    <= cmd;
        i_virt_addr  <= va;
        i_word_index <= widx;
        i_pte_value  <= pte;
        do @(posedge i_clk); while (busy !== 1'b0);
        if (cmd == sv39ptw_pkg::CMD_WRITE) begin
            pte_shadow[word_of(widx[WIDX_W-1:VPN_W], widx[VPN_W-1:0])] = pte;
            r = '0;
        end else begin
            r = walk_tables(va);
        end
        pending_walks.push_back(r);
        items_sent++;
    endtask

    task automatic write_pte(input logic [WIDX_W-1:0] widx, input logic [PTE_W-1:0] pte);
        logic [63:0] junk;
        junk = rand64();
        send_item(sv39ptw_pkg::CMD_WRITE, junk[VA_W-1:0], widx, pte);
    endtask

    task automatic translate(input logic [VA_W-1:0] va);
        logic [63:0] junk;
        junk = rand64();
        send_item(sv39ptw_pkg::CMD_TRANSLATE, va, junk[WIDX_W-1:0], rand64());
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (pending_walks.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic set_root(input logic [PPN_W-1:0] ppn);
        wait_idle();
        i_cfg_we           <= 1'b1;
        i_root_page_number <= ppn;
        @(posedge i_clk);
        i_cfg_we        <= 1'b0;
        root_ppn_shadow  = ppn;
    endtask

    // bad_lvl 2 or 1 drops the valid bit of that pointer
    task automatic build_walk(input logic [VA_W-1:0] va, input logic [PTE_W-1:0] leaf,
                              input int bad_lvl);
        logic [PPN_W-1:0] pg1;
        logic [PPN_W-1:0] pg2;
        logic [PTE_W-1:0] e2;
        logic [PTE_W-1:0] e1;
        pg1 = rand_ppn();
        pg2 = rand_ppn();
        e2  = make_pointer(pg1);
        e1  = make_pointer(pg2);
        if (bad_lvl == 2) e2[PTE_V] = 1'b0;
        if (bad_lvl == 1) e1[PTE_V] = 1'b0;
        write_pte(word_of(root_ppn_shadow, va[38:30]), e2);
        write_pte(word_of(pg1, va[29:21]), e1);
        write_pte(word_of(pg2, va[20:12]), leaf);
    endtask

    function automatic logic [PTE_W-1:0] user_leaf();
        logic [PTE_W-1:0] leaf;
        leaf = rand64();
        leaf[PTE_V] = 1'b1;
        leaf[PTE_U] = 1'b1;
        return leaf;
    endfunction

    task automatic test_cleared_table();
        set_root({PPN_W{1'b1}});
        translate('0);
        translate(39'h40_0000_0000);
        translate({VA_W{1'b1}});
    endtask

    task automatic test_leaf_extremes();
        build_walk(39'h3F_FFFF_FFFF, {PTE_W{1'b1}}, 0);
        translate(39'h3F_FFFF_FFFF);
        set_root('0);
        build_walk('0, 64'h11, 0);
        translate('0);
    endtask

    task automatic test_fault_cases();
        logic [VA_W-1:0] va;
        logic [63:0]     r;
        r  = rand64();
        va = {1'b0, r[37:0]};
        build_walk(va, 64'h1, 0);
        translate(va);
        write_pte(word_of(root_ppn_shadow, va[38:30]), '0);
        translate(va);
        build_walk(va, 64'h3F0, 0);
        translate(va);
        build_walk(va, user_leaf(), 1);
        translate(va);
    endtask

    task automatic test_random_walks(input int target);
        int               pick;
        logic [63:0]      r;
        logic [VA_W-1:0]  va;
        logic [PTE_W-1:0] leaf;
        while (items_sent < target) begin
            idle_allowed = !(items_sent >= 700 && items_sent < 1050);
            if (items_sent >= next_pause) begin
                next_pause += 160;
                case ($urandom_range(0, 3))
                    0: set_root('0);
                    1: set_root({PPN_W{1'b1}});
                    2: set_root(rand_ppn());
                    default: wait_idle();
                endcase
            end
            pick = $urandom_range(0, 99);
            r    = rand64();
            va   = {1'b0, r[37:0]};
            if (pick < 55) begin
                leaf = rand64();
                if ($urandom_range(0, 99) < 85) begin
                    leaf[PTE_V] = 1'b1;
                    leaf[PTE_U] = 1'b1;
                end
                build_walk(va, leaf, 0);
                r = rand64();
                translate({va[VA_W-1:OFF_W], r[OFF_W-1:0]});
                if ($urandom_range(0, 1) == 1)
                    translate({va[VA_W-1:21], r[20:0]});
            end else if (pick < 65) begin
                build_walk(va, user_leaf(), $urandom_range(1, 2));
                translate(va);
            end else if (pick < 80) begin
                write_pte(r[WIDX_W-1:0], rand64());
            end else begin
                translate(r[VA_W-1:0]);
            end
        end
        idle_allowed = 1'b1;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            if (pending_walks.size() == 0) begin
                $display("%0t: result with none expected, got phys_addr %h fault %b",
                         $time, o_phys_addr, o_fault);
                errors++;
            end else begin
                oldest_walk = pending_walks.pop_front();
                if (o_phys_addr !== oldest_walk.pa) begin
                    $display("%0t: phys_addr expected %h got %h",
                             $time, oldest_walk.pa, o_phys_addr);
                    errors++;
                end
                if (o_fault !== oldest_walk.fault) begin
                    $display("%0t: fault expected %b got %b",
                             $time, oldest_walk.fault, o_fault);
                    errors++;
                end
            end
        end
    end

    initial begin
        #2000000;
        $display("sv39_page_table_walker_top: mismatch");
        $finish;
    end

    initial begin
        for (int i = 0; i < TABLE_WORDS; i++) pte_shadow[i] = '0;
        root_ppn_shadow     = '0;
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_root_page_number <= '0;
        start              <= 1'b0;
        i_command          <= sv39ptw_pkg::CMD_WRITE;
        i_virt_addr        <= '0;
        i_word_index       <= '0;
        i_pte_value        <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_cleared_table();
        test_leaf_extremes();
        test_fault_cases();
        test_random_walks(1750);

        wait_idle();
        repeat (16) @(posedge i_clk);
        if (errors == 0)
            $display("sv39_page_table_walker_top: match");
        else
            $display("sv39_page_table_walker_top: mismatch");
        $finish;
    end

endmodule

/* sv39_page_table_walker_top.f */
rtl/sv39ptw_pkg.sv
rtl/sv39ptw_table_ram.sv
rtl/sv39_page_table_walker_top.sv
sim/tb_top.sv
